FILE: rtl/sstf_disk_scheduler_assert.svh
// ----------------------------------------------------------------------------
// SSTF disk scheduler assertion macros
// Shared macros for the concurrent assertions of the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef SSTF_DISK_SCHEDULER_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_ASSERT_SVH

// Clocked assertion with an active-low reset that disables it.
`define SSTF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the usual clock and reset of the scheduler.
`define SSTF_ASSERT(label, prop, msg) \
  `SSTF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Field widths and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

  localparam int unsigned TrackW = 16;
  localparam int unsigned OrderW = 7;
  localparam int unsigned TotalW = 22;

  typedef struct packed {
    logic store;
    logic start_batch;
    logic scan_clear;
    logic scan_step;
    logic commit;
    logic end_batch;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic final_pick;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/sstf_req_if.sv
// ----------------------------------------------------------------------------
// SSTF request channel
// Valid/ready channel that carries one track request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sstf_req_if;
  import sstf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TrackW-1:0] track;
  logic              last;

  modport source (output valid, output track, output last, input ready);
  modport sink (input valid, input track, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/sstf_res_if.sv
// ----------------------------------------------------------------------------
// SSTF result channel
// Valid/ready channel that carries one served request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sstf_res_if;
  import sstf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OrderW-1:0] order;
  logic [TrackW-1:0] served_track;
  logic [TrackW-1:0] seek;
  logic [TotalW-1:0] total_seek;
  logic              final_res;

  modport source (
    output valid, output order, output served_track, output seek,
    output total_seek, output final_res, input ready
  );
  modport sink (
    input valid, input order, input served_track, input seek,
    input total_seek, input final_res, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/sstf_ctrl.sv
// ----------------------------------------------------------------------------
// SSTF scheduler controller
// State machine that collects a batch, runs one scan of the request memory
// per pick and hands each result to the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_last_i,
  output logic            req_ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  input  sstf_pkg::sts_t  sts_i,
  output sstf_pkg::cmd_t  cmd_o
);
  import sstf_pkg::*;

  localparam logic [2:0] StCollect = 3'd0;
  localparam logic [2:0] StScan    = 3'd1;
  localparam logic [2:0] StWait    = 3'd2;
  localparam logic [2:0] StCommit  = 3'd3;
  localparam logic [2:0] StOut     = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      StCollect: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.store = 1'b1;
          if (req_last_i) begin
            cmd_o.start_batch = 1'b1;
            cmd_o.scan_clear  = 1'b1;
            state_d           = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StWait;
        end
      end
      StWait: begin
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (sts_i.final_pick) begin
            cmd_o.end_batch = 1'b1;
            state_d         = StCollect;
          end else begin
            cmd_o.scan_clear = 1'b1;
            state_d          = StScan;
          end
        end
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sstf_dp.sv
// ----------------------------------------------------------------------------
// SSTF scheduler datapath
// Request memory, served bits, nearest-track scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_dp #(
  parameter int unsigned MAX_QUEUE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sstf_pkg::TrackW-1:0]   cfg_wdata_i,
  input  logic [sstf_pkg::TrackW-1:0]   req_track_i,
  input  sstf_pkg::cmd_t                cmd_i,
  output sstf_pkg::sts_t                sts_o,
  output logic [sstf_pkg::OrderW-1:0]   res_order_o,
  output logic [sstf_pkg::TrackW-1:0]   res_track_o,
  output logic [sstf_pkg::TrackW-1:0]   res_seek_o,
  output logic [sstf_pkg::TotalW-1:0]   res_total_o,
  output logic                          res_final_o
);
  import sstf_pkg::*;

  localparam int unsigned IdxW = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;
  localparam int unsigned CntW = $clog2(MAX_QUEUE + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_QUEUE);

  logic [TrackW-1:0]    mem_q [MAX_QUEUE];
  logic [TrackW-1:0]    rd_data_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic                 rd_v_q;

  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      k_q;
  logic [MAX_QUEUE-1:0] served_q, served_d;
  logic [TrackW-1:0]    head_q;
  logic [TotalW-1:0]    sum_q;
  logic [TrackW-1:0]    start_head_q;
  logic [IdxW-1:0]      scan_addr_q;
  logic                 found_q;

  logic [TrackW-1:0]    best_d_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [TrackW-1:0]    best_trk_q;

  logic                 full;
  logic [CntW-1:0]      cnt_m1;
  logic [CntW-1:0]      k_inc;
  logic [TrackW-1:0]    trk_dist;
  logic [TotalW-1:0]    sum_next;
  logic                 take;

  assign full     = (count_q == CntMax);
  assign cnt_m1   = count_q - CntW'(1);
  assign k_inc    = k_q + CntW'(1);
  assign trk_dist = (head_q >= rd_data_q) ? (head_q - rd_data_q) : (rd_data_q - head_q);
  assign sum_next = sum_q + TotalW'(best_d_q);
  assign take     = rd_v_q && !served_q[rd_idx_q] && (!found_q || (trk_dist < best_d_q));

  assign sts_o.scan_done  = (CntW'(scan_addr_q) == cnt_m1);
  assign sts_o.final_pick = res_final_o;

  always_comb begin
    served_d = served_q;
    if (cmd_i.start_batch) begin
      served_d = '0;
    end else if (cmd_i.commit) begin
      served_d[best_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[count_q[IdxW-1:0]] <= req_track_i;
    end
    if (cmd_i.scan_step) begin
      rd_data_q <= mem_q[scan_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      k_q          <= '0;
      served_q     <= '0;
      head_q       <= '0;
      sum_q        <= '0;
      start_head_q <= '0;
      scan_addr_q  <= '0;
      found_q      <= 1'b0;
      rd_v_q       <= 1'b0;
    end else begin
      served_q <= served_d;
      rd_v_q   <= cmd_i.scan_step;
      if (cfg_we_i) begin
        start_head_q <= cfg_wdata_i;
      end
      if (cmd_i.end_batch) begin
        count_q <= '0;
      end else if (cmd_i.store && !full) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.scan_clear) begin
        scan_addr_q <= '0;
        found_q     <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_addr_q <= scan_addr_q + IdxW'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.start_batch) begin
        head_q <= start_head_q;
        sum_q  <= '0;
        k_q    <= '0;
      end else if (cmd_i.commit) begin
        head_q <= best_trk_q;
        sum_q  <= sum_next;
        k_q    <= k_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_addr_q;
    if (take) begin
      best_d_q   <= trk_dist;
      best_idx_q <= rd_idx_q;
      best_trk_q <= rd_data_q;
    end
    if (cmd_i.commit) begin
      res_order_o <= OrderW'(k_inc);
      res_track_o <= best_trk_q;
      res_seek_o  <= best_d_q;
      res_total_o <= sum_next;
      res_final_o <= (k_inc == count_q);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sstf_disk_scheduler.sv
// ----------------------------------------------------------------------------
// SSTF disk scheduler
// Collects a batch of track requests and serves them nearest track first,
// lowest memory index first on equal distance.
//
//   Channel   Direction  Handshake      Payload
//   req_i     in         valid/ready    track, last
//   res_o     out        valid/ready    order, served_track, seek, total_seek,
//                                       final_res
//   cfg       in         cfg_we_i       cfg_wdata_i (start head track)
//
// A request is taken whenever one is valid while the block collects a batch.
// Each result is made by one full scan of the request memory through its
// single read port, then the last compare, then an update of the head and
// the result register, and then the presentation of the result.
// From the last request until the final result is taken no request is
// accepted; a stalled result holds the block in place.
// Reset clears the control state at once; the request memory needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_disk_scheduler #(
  parameter int unsigned MAX_QUEUE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sstf_pkg::TrackW-1:0]  cfg_wdata_i,
  sstf_req_if.sink                     req_i,
  sstf_res_if.source                   res_o
);
  import sstf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sstf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_last_i  (req_i.last),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sstf_dp #(
    .MAX_QUEUE (MAX_QUEUE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_track_i (req_i.track),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_order_o (res_o.order),
    .res_track_o (res_o.served_track),
    .res_seek_o  (res_o.seek),
    .res_total_o (res_o.total_seek),
    .res_final_o (res_o.final_res)
  );

endmodule

`default_nettype wire

FILE: rtl/sstf_chk.sv
// ----------------------------------------------------------------------------
// SSTF scheduler checker
// Port-level assertions on batch sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sstf_disk_scheduler_assert.svh"

module sstf_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_final_i
);

  `SSTF_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")
  `SSTF_ASSERT(a_no_overlap, !(req_ready_i && res_valid_i), "request taken while a result is pending")
  `SSTF_ASSERT(a_final_reopen, res_valid_i && res_ready_i && res_final_i |=> req_ready_i && !res_valid_i, "no return to collecting after the final result")
  `SSTF_ASSERT(a_next_scan, res_valid_i && res_ready_i && !res_final_i |=> !res_valid_i && !req_ready_i, "next result shown without a new scan")

endmodule

bind sstf_disk_scheduler sstf_chk u_sstf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_final_i (res_o.final_res)
);

`default_nettype wire
